>>> design/lfe_pkg.sv
// Shared widths, limits and command type for the linear fit extrapolator.
package lfe_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int FIELD_W     = 16;
    localparam int PRED_W      = 32;
    localparam int FRAC_BITS   = 8;
    localparam int RUNLEN_W    = 11;
    localparam int NUM_COMP    = 3;
    localparam int COMP_W      = $clog2(NUM_COMP);

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int POS_W  = $clog2(MAX_SAMPLES);
    localparam int SV_W   = SAMPLE_BITS + POS_W + 1;
    localparam int SW_W   = SAMPLE_BITS + 2 * POS_W;
    localparam int WP_W   = SAMPLE_BITS + POS_W + 1;
    localparam int PROD_W = SV_W + CNT_W + 1;
    localparam int TRI_W  = SW_W + 2;
    localparam int DIFF_W = ((PROD_W > TRI_W) ? PROD_W : TRI_W) + 1;
    localparam int NUM_W  = DIFF_W + FRAC_BITS + 1;
    localparam int DEN_W  = 2 * CNT_W;
    localparam int BIT_W  = $clog2(NUM_W);

    localparam logic [NUM_W:0] POS_LIM = (NUM_W + 1)'({1'b0, {(PRED_W - 1){1'b1}}});
    localparam logic [NUM_W:0] NEG_LIM = (NUM_W + 1)'({1'b1, {(PRED_W - 1){1'b0}}});

    localparam int IN_TDATA_W   = ((NUM_COMP * FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAY_W    = NUM_COMP * PRED_W + RUNLEN_W;
    localparam int OUT_TDATA_W  = ((OUT_PAY_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W  = 2;

    typedef struct packed {
        logic              acc;
        logic              setup;
        logic              mul;
        logic              num;
        logic              step;
        logic              fin;
        logic              push;
        logic [COMP_W-1:0] comp;
    } t_dp_cmd;

endpackage

>>> design/linear_fit_extrapolator_unit.sv
// Top level of the least-squares linear fit extrapolator.
// Samples arrive one beat per cycle at positions 0..n-1; the beat with tlast
// closes the run. While a run is filling, a beat is taken every cycle even if
// the previous result is still waiting on the output. After the closing beat
// the fit of all three components runs on one shared bit-serial divider, one
// quotient bit per cycle, and then waits for the output register to free up.
// No beat is taken until the result is pushed. Runs beyond MAX_SAMPLES keep
// only the first MAX_SAMPLES samples and report clipped; a one-sample run
// returns that sample and sets single_sample.
module linear_fit_extrapolator_unit
    import lfe_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sample_x, sample_y, sample_z
    input  logic                   s_axis_tlast,  // last_sample
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // pred_x, pred_y, pred_z, run_length, pad
    output logic [OUT_TUSER_W-1:0] m_axis_tuser   // single_sample, clipped
);

    t_dp_cmd w_cmd;

    lfe_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_cmd         (w_cmd)
    );

    lfe_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_tdata (s_axis_tdata),
        .o_tdata (m_axis_tdata),
        .o_tuser (m_axis_tuser)
    );

endmodule

>>> design/lfe_ctrl.sv
// Sequencer for accumulation, the per-component fit and the output register.
module lfe_ctrl
    import lfe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    s_axis_tvalid,
    output logic    s_axis_tready,
    input  logic    s_axis_tlast,
    output logic    m_axis_tvalid,
    input  logic    m_axis_tready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_ACC   = 7'b0000001,
        S_SETUP = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_NUM   = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_PUSH  = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [COMP_W-1:0] r_comp, n_comp;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic              r_out_valid;
    logic              w_accept;
    logic              w_out_free;

    assign s_axis_tready = (r_state == S_ACC);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_comp  = r_comp;
        n_bit   = r_bit;
        o_cmd   = '0;
        o_cmd.comp = r_comp;
        unique case (r_state)
            S_ACC: begin
                o_cmd.acc = w_accept;
                if (w_accept && s_axis_tlast) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_comp  = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_NUM;
            end
            S_NUM: begin
                o_cmd.num = 1'b1;
                n_bit   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_bit = r_bit + 1'b1;
                if (r_bit == BIT_W'(NUM_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                if (r_comp == COMP_W'(NUM_COMP - 1)) begin
                    n_state = S_PUSH;
                end else begin
                    n_comp  = r_comp + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_PUSH: begin
                if (w_out_free) begin
                    o_cmd.push = 1'b1;
                    n_state = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_comp      <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_comp  <= n_comp;
            r_bit   <= n_bit;
            if (o_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> design/lfe_dp.sv
// Sums, numerator build, shared restoring divider, rounding and output beat.
module lfe_dp
    import lfe_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic [IN_TDATA_W-1:0]  i_tdata,
    output logic [OUT_TDATA_W-1:0] o_tdata,
    output logic [OUT_TUSER_W-1:0] o_tuser
);

    logic        [CNT_W-1:0]  r_count;
    logic signed [SV_W-1:0]   r_sv [NUM_COMP];
    logic signed [SW_W-1:0]   r_sw [NUM_COMP];
    logic                     r_dropped;

    logic        [DEN_W-1:0]  r_den;
    logic                     r_single;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [TRI_W-1:0]  r_tri;
    logic        [NUM_W-1:0]  r_quo;
    logic        [DEN_W-1:0]  r_rem;
    logic                     r_neg;
    logic                     r_sat;
    logic        [PRED_W-1:0] r_res [NUM_COMP];

    logic        [PRED_W-1:0] r_out_pred [NUM_COMP];
    logic        [CNT_W-1:0]  r_out_len;
    logic                     r_out_single;
    logic                     r_out_clip;

    logic                     w_room;
    logic        [POS_W-1:0]  w_pos;
    logic signed [SV_W-1:0]   w_sv_sel;
    logic signed [SW_W-1:0]   w_sw_sel;
    logic        [CNT_W-1:0]  w_nm1;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [NUM_W-1:0]  w_num;
    logic        [NUM_W-1:0]  w_mag;
    logic        [DEN_W:0]    w_rem_sh;
    logic                     w_ge;
    logic                     w_round;
    logic        [NUM_W:0]    w_q;
    logic        [PRED_W-1:0] w_res;
    logic                     w_sat;

    assign w_room   = (r_count < CNT_W'(MAX_SAMPLES));
    assign w_pos    = r_count[POS_W-1:0];
    assign w_sv_sel = r_sv[i_cmd.comp];
    assign w_sw_sel = r_sw[i_cmd.comp];
    assign w_nm1    = r_count - 1'b1;
    assign w_diff   = DIFF_W'(r_tri) - DIFF_W'(r_prod);

    always_comb begin
        if (r_single) begin
            w_num = NUM_W'(w_sv_sel) <<< FRAC_BITS;
        end else begin
            w_num = NUM_W'(w_diff) <<< (FRAC_BITS + 1);
        end
        w_mag = w_num[NUM_W-1] ? (NUM_W'(0) - NUM_W'(w_num)) : NUM_W'(w_num);
    end

    assign w_rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});
    assign w_round  = ({r_rem, 1'b0} >= {1'b0, r_den});
    assign w_q      = {1'b0, r_quo} + (NUM_W + 1)'(w_round);

    always_comb begin
        w_sat = 1'b0;
        w_res = '0;
        if (!r_neg) begin
            if (w_q > POS_LIM) begin
                w_sat = 1'b1;
                w_res = {1'b0, {(PRED_W - 1){1'b1}}};
            end else begin
                w_res = w_q[PRED_W-1:0];
            end
        end else begin
            if (w_q > NEG_LIM) begin
                w_sat = 1'b1;
                w_res = {1'b1, {(PRED_W - 1){1'b0}}};
            end else begin
                w_res = PRED_W'(0) - w_q[PRED_W-1:0];
            end
        end
    end

    // run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.push) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
            for (int c = 0; c < NUM_COMP; c++) begin
                r_sv[c] <= '0;
                r_sw[c] <= '0;
            end
        end else if (i_cmd.acc) begin
            if (w_room) begin
                r_count <= r_count + 1'b1;
                for (int c = 0; c < NUM_COMP; c++) begin
                    logic signed [SAMPLE_BITS-1:0] v_y;
                    logic signed [WP_W-1:0]        v_wp;
                    v_y  = i_tdata[c*FIELD_W +: SAMPLE_BITS];
                    v_wp = v_y * $signed({1'b0, w_pos});
                    r_sv[c] <= r_sv[c] + SV_W'(v_y);
                    r_sw[c] <= r_sw[c] + SW_W'(v_wp);
                end
            end else begin
                r_dropped <= 1'b1;
            end
        end
    end

    // fit datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_single <= (r_count == CNT_W'(1));
            r_den    <= (r_count == CNT_W'(1)) ? DEN_W'(1) : DEN_W'(r_count * w_nm1);
        end
        if (i_cmd.mul) begin
            r_prod <= $signed({1'b0, w_nm1}) * w_sv_sel;
            r_tri  <= (TRI_W'(w_sw_sel) <<< 1) + TRI_W'(w_sw_sel);
        end
        if (i_cmd.num) begin
            r_quo <= w_mag;
            r_rem <= '0;
            r_neg <= w_num[NUM_W-1];
        end
        if (i_cmd.step) begin
            r_rem <= w_ge ? DEN_W'(w_rem_sh - {1'b0, r_den}) : DEN_W'(w_rem_sh);
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
        if (i_cmd.fin) begin
            r_res[i_cmd.comp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_sat <= 1'b0;
        end else if (i_cmd.fin && w_sat) begin
            r_sat <= 1'b1;
        end
    end

    // output beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            for (int c = 0; c < NUM_COMP; c++) begin
                r_out_pred[c] <= r_res[c];
            end
            r_out_len    <= r_count;
            r_out_single <= r_single;
            r_out_clip   <= r_dropped || r_sat;
        end
    end

    assign o_tdata = OUT_TDATA_W'({RUNLEN_W'(r_out_len), r_out_pred[2], r_out_pred[1],
                                   r_out_pred[0]});
    assign o_tuser = {r_out_clip, r_out_single};

endmodule
